FILE: src/nsfe_pkg.sv
// Shared types and character constants for the NMEA sentence field extractor.
package nsfe_pkg;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_SEP   = 8'h2C;  // ','
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Register file layout.
  localparam int unsigned HDR_TEXT_W = 40;
  localparam int unsigned REP_SEL_W  = 4;
  localparam int unsigned FLD_SEL_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // Occurrence counter counts to sixteen and holds; comma counter holds at 63.
  localparam int unsigned MATCH_CNT_W = 5;
  localparam logic [MATCH_CNT_W-1:0] MATCH_SAT = 5'd16;
  localparam int unsigned COMMA_CNT_W = 6;
  localparam logic [COMMA_CNT_W-1:0] COMMA_SAT = 6'd63;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_TEXT   = 2'd0,
    CFG_REPEAT_SELECT = 2'd1,
    CFG_FIELD_SELECT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [HDR_TEXT_W-1:0] header_text;
    logic [REP_SEL_W-1:0]  repeat_select;
    logic [FLD_SEL_W-1:0]  field_select;
  } nsfe_cfg_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       buffer_start;
  } nsfe_in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       field_done;
    logic       field_found;
  } nsfe_out_t;

endpackage

FILE: src/nsfe_parser.sv
// Per-byte parse state and the combinational update that yields one result per byte.
module nsfe_parser import nsfe_pkg::*; #(
  parameter int unsigned HEADER_CHARS = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  nsfe_in_t  in_i,
  input  nsfe_cfg_t cfg_i,
  output nsfe_out_t res_o
);

  localparam int unsigned HW = 8 * HEADER_CHARS;
  localparam int unsigned PW = $clog2(HEADER_CHARS + 1);

  logic                   in_header_q, in_header_d;
  logic                   after_dollar_q, after_dollar_d;
  logic [PW-1:0]          header_pos_q, header_pos_d;
  logic [HW-1:0]          header_shift_q, header_shift_d;
  logic [MATCH_CNT_W-1:0] match_count_q, match_count_d;
  logic [COMMA_CNT_W-1:0] comma_count_q, comma_count_d;
  logic                   data_active_q, data_active_d;
  logic                   done_q, done_d;
  logic                   found_q, found_d;
  logic                   trimmed_q, trimmed_d;

  logic [63:0]   text_ext;
  logic [HW-1:0] hdr_ref;
  logic [7:0]    c;

  // Header text is zero extended above bit 39 and cut to the header width.
  assign text_ext = 64'(cfg_i.header_text);
  assign hdr_ref  = text_ext[HW-1:0];
  assign c        = in_i.byte_in;

  // Next state and result for the byte at the input.
  always_comb begin
    logic clr;
    clr            = in_i.buffer_start;
    in_header_d    = clr ? 1'b0 : in_header_q;
    after_dollar_d = clr ? 1'b0 : after_dollar_q;
    header_pos_d   = clr ? '0 : header_pos_q;
    header_shift_d = clr ? '0 : header_shift_q;
    match_count_d  = clr ? '0 : match_count_q;
    comma_count_d  = clr ? '0 : comma_count_q;
    data_active_d  = clr ? 1'b0 : data_active_q;
    done_d         = clr ? 1'b0 : done_q;
    found_d        = clr ? 1'b0 : found_q;
    trimmed_d      = clr ? 1'b0 : trimmed_q;
    res_o          = '0;

    if (!done_d) begin
      if (!after_dollar_d && c == CH_START) begin
        // A '$' opens a new header; the byte right after it is never taken as another '$'.
        in_header_d    = 1'b1;
        after_dollar_d = 1'b1;
        header_pos_d   = '0;
        data_active_d  = 1'b0;
      end else begin
        after_dollar_d = 1'b0;
        if (in_header_d) begin
          if (c == CH_SEP || header_pos_d >= PW'(HEADER_CHARS)) begin
            in_header_d = 1'b0;
          end else begin
            header_shift_d = {header_shift_d[HW-9:0], c};
            if (header_pos_d == PW'(HEADER_CHARS - 1)) begin
              in_header_d = 1'b0;
              if (header_shift_d == hdr_ref) begin
                if (match_count_d == {1'b0, cfg_i.repeat_select}) begin
                  data_active_d = 1'b1;
                end
                if (match_count_d < MATCH_SAT) begin
                  match_count_d = match_count_d + 1'b1;
                end
              end
            end
            header_pos_d = header_pos_d + 1'b1;
          end
        end
        // Inside the selected sentence: count commas and pass field characters.
        if (data_active_d) begin
          if (comma_count_d == {1'b0, cfg_i.field_select} && c != CH_SEP) begin
            if (c == CH_CR || c == CH_LF) begin
              trimmed_d = 1'b1;
            end else if (!trimmed_d) begin
              res_o.char_valid = 1'b1;
              res_o.out_char   = c;
              found_d          = 1'b1;
            end
          end
          if (c == CH_SEP && comma_count_d < COMMA_SAT) begin
            comma_count_d = comma_count_d + 1'b1;
          end
          if (comma_count_d > {1'b0, cfg_i.field_select}) begin
            done_d = 1'b1;
          end
        end
      end
    end

    res_o.field_done  = done_d;
    res_o.field_found = found_d;
  end

  // State advances only when a byte is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q    <= 1'b0;
      after_dollar_q <= 1'b0;
      header_pos_q   <= '0;
      header_shift_q <= '0;
      match_count_q  <= '0;
      comma_count_q  <= '0;
      data_active_q  <= 1'b0;
      done_q         <= 1'b0;
      found_q        <= 1'b0;
      trimmed_q      <= 1'b0;
    end else if (step_i) begin
      in_header_q    <= in_header_d;
      after_dollar_q <= after_dollar_d;
      header_pos_q   <= header_pos_d;
      header_shift_q <= header_shift_d;
      match_count_q  <= match_count_d;
      comma_count_q  <= comma_count_d;
      data_active_q  <= data_active_d;
      done_q         <= done_d;
      found_q        <= found_d;
      trimmed_q      <= trimmed_d;
    end
  end

endmodule

FILE: src/nmea_sentence_field_extractor.sv
// Top level of the NMEA sentence field extractor: config registers, parser and output skid.
//
// Usage: text bytes enter on the in_valid_i/in_ready_o channel, one byte per request,
// with buffer_start set on the first byte of a new buffer. Every byte yields exactly one
// result request on out_valid_o/out_ready_i carrying char_valid, out_char, field_done
// and field_found. The field to extract is chosen by the header text, its occurrence
// index and the field number, written through cfg_we_i/cfg_idx_i/cfg_data_i while no
// byte is in flight.
// Result path: each result is registered in the output register, else in the skid register.
// Throughput: one byte per cycle while in_ready_o is high; the parse state is updated by a
// single pass of logic from the accepted byte, and the result lands in an output register.
// Stall: a two-entry output stage (output register plus skid register) lets one more
// byte be taken while a result waits; in_ready_o drops only when both entries are full.
// Reset: clears the parse state, empties the output stage and loads the register
// defaults (header text zero, occurrence zero, field one).
module nmea_sentence_field_extractor import nsfe_pkg::*; #(
  parameter int unsigned HEADER_CHARS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nsfe_in_t              in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output nsfe_out_t             out_req_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [HDR_TEXT_W-1:0] cfg_data_i
);

  nsfe_cfg_t cfg_q;
  nsfe_out_t res;
  nsfe_out_t main_q, skid_q;
  logic      main_vld_q, skid_vld_q;
  logic      in_fire, out_fire;

  assign in_ready_o  = !skid_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = main_vld_q;
  assign out_fire    = main_vld_q && out_ready_i;
  assign out_req_o   = main_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_text   <= '0;
      cfg_q.repeat_select <= '0;
      cfg_q.field_select  <= FLD_SEL_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEADER_TEXT:   cfg_q.header_text   <= cfg_data_i;
        CFG_REPEAT_SELECT: cfg_q.repeat_select <= cfg_data_i[REP_SEL_W-1:0];
        CFG_FIELD_SELECT:  cfg_q.field_select  <= cfg_data_i[FLD_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  nsfe_parser #(
    .HEADER_CHARS(HEADER_CHARS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .in_i   (in_req_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Output register and skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_fire) begin
      main_vld_q <= skid_vld_q || in_fire;
      skid_vld_q <= 1'b0;
    end else if (in_fire) begin
      if (!main_vld_q) begin
        main_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      main_q <= skid_vld_q ? skid_q : res;
    end else if (in_fire) begin
      if (!main_vld_q) begin
        main_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> main_vld_q)
    else $error("skid entry holds a result while the output register is empty");

  // A result without a field character carries a zero character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.char_valid) |-> (out_req_o.out_char == 8'h00))
    else $error("out_char is nonzero without char_valid");

  // An emitted character always belongs to a field that has not yet ended.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_req_o.char_valid) |-> (out_req_o.field_found && !out_req_o.field_done))
    else $error("character emitted with inconsistent found or done flags");

endmodule

FILE: tb/sv/nmea_sentence_field_extractor_tb.sv
// Self-checking testbench for the NMEA sentence field extractor, with a byte-level parser model.
module nmea_sentence_field_extractor_tb;
  import nsfe_pkg::*;

  localparam int HDR_CHARS   = 5;
  localparam int STALL_LIMIT = 3000;

  localparam logic [HDR_TEXT_W-1:0] HDR_GPGGA = "GPGGA";
  localparam logic [HDR_TEXT_W-1:0] HDR_DGPGG = "$GPGG";
  localparam logic [HDR_TEXT_W-1:0] HDR_GNRMC = "GNRMC";
  localparam logic [HDR_TEXT_W-1:0] HDR_ONES  = '1;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  nsfe_in_t              in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  nsfe_out_t             out_req_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [HDR_TEXT_W-1:0] cfg_data_i;

  nmea_sentence_field_extractor #(
    .HEADER_CHARS(HDR_CHARS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Byte requests waiting to be sent and field results waiting to arrive.
  nsfe_in_t  text_bytes[$];
  nsfe_out_t field_results[$];

  int tx_idle_pct;
  int rx_idle_pct;
  int error_count;
  int stall_cycles;
  int pushed_total;
  bit new_buffer;
  bit scatter_starts;

  // Shadow copy of the register file.
  logic [HDR_TEXT_W-1:0]  cfg_header;
  logic [REP_SEL_W-1:0]   cfg_repeat;
  logic [FLD_SEL_W-1:0]   cfg_field;

  // Parser state of the model.
  logic                     prs_in_header;
  logic                     prs_after_dollar;
  logic [2:0]               prs_header_pos;
  logic [8*HDR_CHARS-1:0]   prs_header_shift;
  logic [MATCH_CNT_W-1:0]   prs_match_count;
  logic [COMMA_CNT_W-1:0]   prs_comma_count;
  logic                     prs_data_active;
  logic                     prs_done;
  logic                     prs_found;
  logic                     prs_trimmed;

  nsfe_out_t want;

  function automatic void clear_parse_state();
    prs_in_header    = 1'b0;
    prs_after_dollar = 1'b0;
    prs_header_pos   = '0;
    prs_header_shift = '0;
    prs_match_count  = '0;
    prs_comma_count  = '0;
    prs_data_active  = 1'b0;
    prs_done         = 1'b0;
    prs_found        = 1'b0;
    prs_trimmed      = 1'b0;
  endfunction

  // Advance the parser by one byte and return the field result it produces.
  function automatic nsfe_out_t extract_step(nsfe_in_t item);
    logic [7:0] c;
    nsfe_out_t  res;
    c   = item.byte_in;
    res = '0;
    if (item.buffer_start) clear_parse_state();
    if (!prs_done) begin
      if (!prs_after_dollar && c == CH_START) begin
        prs_in_header    = 1'b1;
        prs_after_dollar = 1'b1;
        prs_header_pos   = '0;
        prs_data_active  = 1'b0;
      end else begin
        prs_after_dollar = 1'b0;
        if (prs_in_header) begin
          // A separator inside the header cuts it short.
          if (c == CH_SEP || prs_header_pos >= HDR_CHARS) begin
            prs_in_header = 1'b0;
          end else begin
            prs_header_shift = {prs_header_shift[8*HDR_CHARS-9:0], c};
            if (prs_header_pos == HDR_CHARS - 1) begin
              prs_in_header = 1'b0;
              if (prs_header_shift == cfg_header[8*HDR_CHARS-1:0]) begin
                if (prs_match_count == {1'b0, cfg_repeat}) prs_data_active = 1'b1;
                if (prs_match_count < MATCH_SAT) prs_match_count = prs_match_count + 1'b1;
              end
            end
            prs_header_pos = prs_header_pos + 1'b1;
          end
        end
        if (prs_data_active) begin
          // Inside the selected field: CR or LF ends emission for the buffer.
          if (prs_comma_count == {1'b0, cfg_field} && c != CH_SEP) begin
            if (c == CH_CR || c == CH_LF) begin
              prs_trimmed = 1'b1;
            end else if (!prs_trimmed) begin
              res.char_valid = 1'b1;
              res.out_char   = c;
              prs_found      = 1'b1;
            end
          end
          if (c == CH_SEP && prs_comma_count < COMMA_SAT)
            prs_comma_count = prs_comma_count + 1'b1;
          if (prs_comma_count > {1'b0, cfg_field}) prs_done = 1'b1;
        end
      end
    end
    res.field_done  = prs_done;
    res.field_found = prs_found;
    return res;
  endfunction

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 4) return 8'($urandom_range(255));
    return 8'($urandom_range(8'h5A, 8'h2D));
  endfunction

  task automatic push_byte(logic [7:0] b);
    nsfe_in_t item;
    item.byte_in      = b;
    item.buffer_start = new_buffer || (scatter_starts && $urandom_range(99) == 0);
    new_buffer        = 1'b0;
    text_bytes.push_back(item);
    pushed_total++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // One sentence: start, header (usually the configured one), fields and mostly a line end.
  task automatic gen_sentence(int max_fields);
    int         kind;
    int         n_fields;
    int         n_chars;
    int         hex;
    logic [7:0] b;
    if ($urandom_range(9) == 0) push_byte(rand_char());
    push_byte(CH_START);
    if ($urandom_range(9) == 0) push_byte(CH_START);
    kind = $urandom_range(99);
    for (int k = 0; k < HDR_CHARS; k++) begin
      b = cfg_header[8*(HDR_CHARS-1-k) +: 8];
      if (kind >= 70 && kind < 85 && k == 2) b = rand_char();
      else if (kind >= 85 && kind < 93) b = 8'($urandom_range(255));
      if (kind >= 93 && k == 3) begin
        push_byte(CH_SEP);
        break;
      end
      push_byte(b);
    end
    if ($urandom_range(1)) n_fields = max_fields - $urandom_range(3);
    else n_fields = $urandom_range(max_fields);
    for (int f = 0; f < n_fields; f++) begin
      push_byte(CH_SEP);
      n_chars = $urandom_range(4);
      for (int i = 0; i < n_chars; i++) push_byte(rand_char());
    end
    kind = $urandom_range(99);
    if (kind < 75) begin
      push_byte("*");
      for (int i = 0; i < 2; i++) begin
        hex = $urandom_range(15);
        push_byte(hex < 10 ? 8'("0" + hex) : 8'("A" + hex - 10));
      end
      push_byte(CH_CR);
      push_byte(CH_LF);
    end else if (kind < 85) begin
      push_byte(CH_LF);
    end else if (kind < 90) begin
      push_byte(CH_CR);
      push_byte(rand_char());
    end
  endtask

  // Random buffers until the requested number of bytes is queued.
  task automatic gen_random(int target);
    int base;
    int n_sent;
    base = pushed_total;
    while (pushed_total - base < target) begin
      new_buffer = 1'b1;
      if ($urandom_range(1)) n_sent = int'(cfg_repeat) + 1 + $urandom_range(2);
      else n_sent = $urandom_range(3, 1);
      for (int s = 0; s < n_sent; s++) gen_sentence(int'(cfg_field) + 2);
    end
  endtask

  task automatic wait_drained();
    while (text_bytes.size() != 0 || in_valid_i || field_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [HDR_TEXT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_HEADER_TEXT:   cfg_header = value;
      CFG_REPEAT_SELECT: cfg_repeat = value[REP_SEL_W-1:0];
      CFG_FIELD_SELECT:  cfg_field  = value[FLD_SEL_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Registers change only once every byte has been answered.
  task automatic apply_config(logic [HDR_TEXT_W-1:0] hdr, int rep, int fld);
    wait_drained();
    repeat (2) @(posedge clk_i);
    cfg_write(CFG_HEADER_TEXT, hdr);
    cfg_write(CFG_REPEAT_SELECT, HDR_TEXT_W'(rep));
    cfg_write(CFG_FIELD_SELECT, HDR_TEXT_W'(fld));
  endtask

  // Clock.
  always #5 clk_i = ~clk_i;

  // Byte driver: predicts each accepted request, then offers the next one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) field_results.push_back(extract_step(in_req_i));
      if (!in_valid_i || in_ready_o) begin
        if (text_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_req_i   <= text_bytes.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (field_results.size() == 0) begin
          $error("unexpected result request %p", out_req_o);
          error_count++;
        end else begin
          want = field_results.pop_front();
          if (out_req_o.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0h, actual %0h", want.char_valid,
                   out_req_o.char_valid);
            error_count++;
          end
          if (out_req_o.out_char !== want.out_char) begin
            $error("out_char: expected %0h, actual %0h", want.out_char, out_req_o.out_char);
            error_count++;
          end
          if (out_req_o.field_done !== want.field_done) begin
            $error("field_done: expected %0h, actual %0h", want.field_done,
                   out_req_o.field_done);
            error_count++;
          end
          if (out_req_o.field_found !== want.field_found) begin
            $error("field_found: expected %0h, actual %0h", want.field_found,
                   out_req_o.field_found);
            error_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    logic [HDR_TEXT_W-1:0] rand_hdr;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    tx_idle_pct    = 15;
    rx_idle_pct    = 55;
    error_count    = 0;
    stall_cycles   = 0;
    pushed_total   = 0;
    new_buffer     = 1'b0;
    scatter_starts = 1'b0;
    clear_parse_state();
    cfg_header = '0;
    cfg_repeat = '0;
    cfg_field  = 5'd1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a cut-short header, a first match that is skipped, the second match
    // selected with field zero, a CR ending emission, bytes after done, extreme bytes.
    apply_config(HDR_GPGGA, 1, 0);
    new_buffer = 1'b1;
    push_text("$GP,");
    push_text("$GPGGA");
    push_text("$GPGGA");
    push_text("\rB,");
    push_byte(8'hFF);
    new_buffer = 1'b1;
    push_byte(8'hFF);
    push_byte(8'h00);

    // Random sentences, sender idling less than the receiver.
    scatter_starts = 1'b1;
    apply_config(HDR_GPGGA, 0, 1);
    gen_random(85);
    apply_config('0, 0, 2);
    gen_random(85);

    // Receiver idling less than the sender.
    apply_config(HDR_ONES, 15, 3);
    tx_idle_pct <= 55;
    rx_idle_pct <= 15;
    gen_random(85);
    apply_config(HDR_DGPGG, 0, 31);
    gen_random(85);

    // No idling on either side.
    rand_hdr = '0;
    for (int k = 0; k < HDR_CHARS; k++)
      rand_hdr = {rand_hdr[HDR_TEXT_W-9:0], 8'($urandom_range(8'h5A, 8'h41))};
    apply_config(rand_hdr, $urandom_range(3), $urandom_range(8));
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    gen_random(85);
    apply_config(HDR_GNRMC, 0, 0);
    gen_random(85);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (field_results.size() != 0) begin
      $error("%0d predicted results never arrived", field_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
